// File: rtl/lsf_pkg.sv
package lsf_pkg;

  localparam int LINE_CAPACITY = 1024;
  localparam int MAX_NEEDLE    = 32;

  // Current line length counts up to LINE_CAPACITY-1.
  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam int EFF_W = $clog2(MAX_NEEDLE + 1);

  localparam int NDL_REGS  = 4;
  localparam int NDL_BYTES = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NLEN_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_NDL0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NDL1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NDL2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NDL3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NLEN = 3'd4;

  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // Needle as the cells see it: enable per cell, the byte each cell compares
  // against, and whether the effective needle is empty.
  typedef struct packed {
    logic [MAX_NEEDLE-1:0]      en;
    logic [MAX_NEEDLE-1:0][7:0] aligned;
    logic                       empty;
  } ndl_cfg_t;

endpackage

// File: rtl/lsf_cell.sv
module lsf_cell
  import lsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic       en_i,
  input  logic [7:0] ndl_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       hit_o
);

  logic [7:0] byte_q;
  logic       valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // Compare the byte that this cell will hold after the shift.
  assign hit_o   = !en_i || (valid_i && (byte_i == ndl_i));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/lsf_needle_cfg.sv
module lsf_needle_cfg
  import lsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output ndl_cfg_t             ndl_o
);

  logic [NDL_REGS-1:0][CFG_W-1:0] ndl_q, ndl_d;
  logic [NLEN_W-1:0]              nlen_q, nlen_d;
  logic [NDL_BYTES-1:0][7:0]      bytes_d;
  logic [NLEN_W-1:0]              lim;
  logic [MAX_NEEDLE-1:0]          nz;
  logic [MAX_NEEDLE-1:0]          en_d, en_q;
  logic [MAX_NEEDLE-1:0][7:0]     aligned_d, aligned_q;
  logic [EFF_W-1:0]               eff;
  logic                           empty_q;

  always_comb begin
    ndl_d  = ndl_q;
    nlen_d = nlen_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NDL0: ndl_d[0] = cfg_wdata_i;
        REG_NDL1: ndl_d[1] = cfg_wdata_i;
        REG_NDL2: ndl_d[2] = cfg_wdata_i;
        REG_NDL3: ndl_d[3] = cfg_wdata_i;
        REG_NLEN: nlen_d   = cfg_wdata_i[NLEN_W-1:0];
        default:  ;
      endcase
    end
  end

  assign bytes_d = ndl_d;
  assign lim = (nlen_d > NLEN_W'(MAX_NEEDLE)) ? NLEN_W'(MAX_NEEDLE) : nlen_d;

  // A cell is in use when it lies below the length limit and no needle byte
  // up to its own position is zero.
  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_en
    assign nz[i]   = (bytes_d[i] != 8'h00);
    assign en_d[i] = (NLEN_W'(i) < lim) && (&nz[i:0]);
  end

  assign eff = EFF_W'($countones(en_d));

  // Cell i holds the i-th newest byte, which lines up with needle byte eff-1-i.
  always_comb begin
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      pos          = 6'(eff) - 6'(i) - 6'd1;
      aligned_d[i] = bytes_d[pos[4:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndl_q   <= '0;
      nlen_q  <= '0;
      en_q    <= '0;
      empty_q <= 1'b1;
    end else begin
      ndl_q   <= ndl_d;
      nlen_q  <= nlen_d;
      en_q    <= en_d;
      empty_q <= !en_d[0];
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_d;
  end

  assign ndl_o.en      = en_q;
  assign ndl_o.aligned = aligned_q;
  assign ndl_o.empty   = empty_q;

endmodule

// File: rtl/line_substring_filter.sv
// Channel   Dir  tdata (low bit up)                              tuser
// s_axis    in   [7:0] data_byte                                 [0] end_of_input
// m_axis    out  [0] line_matched, [10:1] line_length,           [0] from_flush
//                [26:11] matches_so_far, [31:27] zero
// cfg       in   cfg_we_i, cfg_idx_i (register 0..4), cfg_wdata_i
//
// One beat per clock while s_axis_tready_o is high: each stored byte before the
// first zero byte shifts through a row of 32 compare cells, and the window match
// is folded into the line state in that cycle. The output register takes a result
// on the ending beat. Input is taken whenever the output register is empty or drains
// this cycle. Reset clears the line state, the match count and the needle registers.
module line_substring_filter
  import lsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,  // [7:0] data_byte
  input  logic [0:0]           s_axis_tuser_i,  // [0] end_of_input
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,  // [0] matched, [10:1] length, [26:11] count
  output logic [0:0]           m_axis_tuser_o,  // [0] from_flush
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  ndl_cfg_t ndl;

  logic                       s_acc;
  logic                       in_end;
  logic [7:0]                 in_byte;
  logic                       finish, flush, store, shift;
  logic                       clear;
  logic                       match;
  logic                       window_hit;

  logic [LEN_W-1:0]           len_q, len_d;
  logic                       zero_q, zero_d;
  logic                       hit_q, hit_d;
  logic [15:0]                total_q, total_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_match_q;
  logic [9:0]                 out_len_q;
  logic [15:0]                out_total_q;
  logic                       out_flush_q;

  logic [MAX_NEEDLE-1:0][7:0] cell_byte;
  logic [MAX_NEEDLE-1:0]      cell_valid;
  logic [MAX_NEEDLE-1:0]      cell_hit;

  lsf_needle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ndl_o       (ndl)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_end  = s_axis_tuser_i[0];
  assign in_byte = s_axis_tdata_i;

  assign flush  = s_acc && in_end && (len_q != '0);
  assign finish = flush || (s_acc && !in_end &&
                  ((in_byte == NEWLINE_BYTE) || (len_q >= LEN_W'(LINE_CAPACITY - 1))));
  assign store  = s_acc && !in_end && !finish;
  // The first zero byte and all bytes after it only count toward the length.
  assign shift  = store && !zero_q && (in_byte != 8'h00);
  assign clear  = finish;

  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
    lsf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear),
      .byte_i  ((i == 0) ? in_byte : cell_byte[(i == 0) ? 0 : i - 1]),
      .valid_i ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i - 1]),
      .en_i    (ndl.en[i]),
      .ndl_i   (ndl.aligned[i]),
      .byte_o  (cell_byte[i]),
      .valid_o (cell_valid[i]),
      .hit_o   (cell_hit[i])
    );
  end

  assign window_hit = (&cell_hit) && !ndl.empty;
  assign match      = hit_q || ndl.empty;

  always_comb begin
    len_d   = len_q;
    zero_d  = zero_q;
    hit_d   = hit_q;
    total_d = total_q;
    if (finish) begin
      len_d  = '0;
      zero_d = 1'b0;
      hit_d  = 1'b0;
      if (match && (total_q != COUNT_MAX)) begin
        total_d = total_q + 16'd1;
      end
    end else if (store) begin
      len_d = len_q + LEN_W'(1);
      if (!zero_q && (in_byte == 8'h00)) begin
        zero_d = 1'b1;
      end
      if (shift && window_hit) begin
        hit_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      zero_q      <= 1'b0;
      hit_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      zero_q      <= zero_d;
      hit_q       <= hit_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_match_q <= match;
      out_len_q   <= 10'(len_q);
      out_total_q <= total_d;
      out_flush_q <= flush;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {5'b0, out_total_q, out_len_q, out_match_q};
  assign m_axis_tuser_o[0] = out_flush_q;

endmodule
